@@ rtl/core/lru_page_replacement_core_defines.svh @@
// Assertion macros used by the LRU replacement core RTL.
`ifndef LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lrupr_pkg.sv @@
`default_nettype none

package lrupr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 8;
  localparam int SLOT_W    = $clog2(FRAMES);
  localparam int RANK_W    = 4;
  localparam int HIT_W     = 16;
  localparam int CFG_W     = 5;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [HIT_W-1:0]     hit_cnt_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [FRAMES-1:0]    frame_mask_t;
  typedef page_t [FRAMES-1:0]   page_vec_t;
  typedef rank_t [FRAMES-1:0]   rank_vec_t;

  localparam cfg_t  CFG_RESET = cfg_t'(3);
  localparam rank_t RANK_MAX  = '1;

  // Outcome of the frame lookup for one reference
  typedef struct packed {
    logic  hit;
    slot_t slot;
    logic  evict;
    page_t evict_page;
  } search_t;

  function automatic rank_t rank_inc(input rank_t r);
    rank_t res;
    res = (r == RANK_MAX) ? r : r + rank_t'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lrupr_search.sv @@
`default_nettype none

module lrupr_search (
  input  lrupr_pkg::page_t       page,
  input  lrupr_pkg::frame_mask_t active,
  input  lrupr_pkg::frame_mask_t valid,
  input  lrupr_pkg::page_vec_t   pages,
  input  lrupr_pkg::rank_vec_t   ranks,
  output lrupr_pkg::search_t     res
);
  import lrupr_pkg::*;

  localparam int LEVELS = SLOT_W;
  localparam int LEAVES = 2 ** SLOT_W;

  frame_mask_t match;
  frame_mask_t empty;
  logic        any_match;
  logic        any_empty;
  slot_t       match_slot;
  slot_t       empty_slot;
  slot_t       victim_slot;

  // oldest-frame tree, left child holds the lower indices so ties go left
  logic  tv [LEVELS+1][LEAVES];
  rank_t tr [LEVELS+1][LEAVES];
  slot_t ti [LEVELS+1][LEAVES];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = active[i] & valid[i] & (pages[i] == page);
      empty[i] = active[i] & ~valid[i];
    end
    any_match = |match;
    any_empty = |empty;

    match_slot = '0;
    empty_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) match_slot = slot_t'(i);
      if (empty[i]) empty_slot = slot_t'(i);
    end
  end

  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int n = 0; n < LEAVES; n++) begin
        tv[l][n] = 1'b0;
        tr[l][n] = '0;
        ti[l][n] = '0;
      end
    end
    for (int n = 0; n < LEAVES; n++) begin
      if (n < FRAMES) begin
        tv[0][n] = active[n];
        tr[0][n] = ranks[n];
        ti[0][n] = slot_t'(n);
      end
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int n = 0; n < (LEAVES >> (l + 1)); n++) begin
        if (tv[l][2*n+1] && (!tv[l][2*n] || (tr[l][2*n+1] > tr[l][2*n]))) begin
          tr[l+1][n] = tr[l][2*n+1];
          ti[l+1][n] = ti[l][2*n+1];
        end else begin
          tr[l+1][n] = tr[l][2*n];
          ti[l+1][n] = ti[l][2*n];
        end
        tv[l+1][n] = tv[l][2*n] | tv[l][2*n+1];
      end
    end
    victim_slot = ti[LEVELS][0];
  end

  always_comb begin
    res.hit        = any_match;
    res.evict      = ~any_match & ~any_empty;
    res.slot       = any_match ? match_slot : (any_empty ? empty_slot : victim_slot);
    res.evict_page = res.evict ? pages[victim_slot] : '0;
  end

endmodule

`default_nettype wire

@@ rtl/core/lrupr_state.sv @@
`default_nettype none

module lrupr_state (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    upd,
  input  lrupr_pkg::page_t       page,
  input  wire                    eos,
  input  lrupr_pkg::frame_mask_t active,
  input  lrupr_pkg::search_t     res,
  output lrupr_pkg::page_vec_t   pages,
  output lrupr_pkg::frame_mask_t valid,
  output lrupr_pkg::rank_vec_t   ranks,
  output lrupr_pkg::hit_cnt_t    hit_total
);
  import lrupr_pkg::*;

  page_vec_t   pages_r, pages_nxt;
  frame_mask_t valid_r, valid_nxt;
  rank_vec_t   ranks_r, ranks_nxt;
  hit_cnt_t    hit_cnt_r, hit_cnt_nxt;
  hit_cnt_t    hit_cnt_after;
  rank_t       hit_rank;

  always_comb begin
    hit_cnt_after = (res.hit && (hit_cnt_r != '1)) ? hit_cnt_r + hit_cnt_t'(1) : hit_cnt_r;
    hit_rank      = ranks_r[res.slot];

    pages_nxt   = pages_r;
    valid_nxt   = valid_r;
    ranks_nxt   = ranks_r;
    hit_cnt_nxt = hit_cnt_r;

    if (upd) begin
      // on a hit only frames newer than the hit frame age; on a miss all age
      for (int i = 0; i < FRAMES; i++) begin
        if (active[i] && valid_r[i] && (slot_t'(i) != res.slot)) begin
          if (!res.hit || (ranks_r[i] < hit_rank)) ranks_nxt[i] = rank_inc(ranks_r[i]);
        end
      end
      ranks_nxt[res.slot] = '0;
      valid_nxt[res.slot] = 1'b1;
      pages_nxt[res.slot] = page;
      hit_cnt_nxt         = hit_cnt_after;
      if (eos) begin
        valid_nxt   = '0;
        ranks_nxt   = '0;
        hit_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      ranks_r   <= '0;
      hit_cnt_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      ranks_r   <= ranks_nxt;
      hit_cnt_r <= hit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pages_r <= pages_nxt;
  end

  assign pages     = pages_r;
  assign valid     = valid_r;
  assign ranks     = ranks_r;
  assign hit_total = hit_cnt_after;

endmodule

`default_nettype wire

@@ rtl/core/lru_page_replacement_core.sv @@
// LRU page replacement core.
// Pipeline: an input register, then a result register that loads when the output is free.
// Throughput: one reference per cycle while out_ready is high; the lookup over all frames,
// the victim tree and the rank update all settle between the input and result registers.
// Reset (rst_n low, synchronous): all frames empty, ranks and hit count zero,
// frames_in_use back to 3; page contents are not cleared and need no sweep.
`default_nettype none

`include "lru_page_replacement_core_defines.svh"

module lru_page_replacement_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_wr_en,
  input  lrupr_pkg::cfg_t          cfg_wr_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  lrupr_pkg::page_t         in_page,
  input  wire                      in_end_of_sequence,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic                     out_hit,
  output lrupr_pkg::slot_t         out_frame_slot,
  output logic                     out_evicted_valid,
  output lrupr_pkg::page_t         out_evicted_page,
  output lrupr_pkg::hit_cnt_t      out_hit_total
);
  import lrupr_pkg::*;

  cfg_t        frames_r;
  cfg_t        frames_act;
  frame_mask_t active;

  logic        s1_v_r, s1_v_nxt;
  page_t       s1_page_r;
  logic        s1_eos_r;
  logic        fire;

  page_vec_t   pages;
  frame_mask_t valid;
  rank_vec_t   ranks;
  hit_cnt_t    hit_total;
  search_t     res;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r;
  slot_t       out_slot_r;
  logic        out_evict_r;
  page_t       out_evict_page_r;
  hit_cnt_t    out_hit_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) frames_r <= CFG_RESET;
    else if (cfg_wr_en) frames_r <= cfg_wr_data;
  end

  // zero acts as one frame, anything above the frame count as all frames
  always_comb begin
    if (frames_r == '0) frames_act = cfg_t'(1);
    else if (frames_r > cfg_t'(FRAMES)) frames_act = cfg_t'(FRAMES);
    else frames_act = frames_r;
    for (int i = 0; i < FRAMES; i++) active[i] = cfg_t'(i) < frames_act;
  end

  assign fire     = s1_v_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_v_r | fire;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_valid && in_ready) s1_v_nxt = 1'b1;
    else if (fire) s1_v_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_page_r <= in_page;
      s1_eos_r  <= in_end_of_sequence;
    end
    if (fire) begin
      out_hit_r        <= res.hit;
      out_slot_r       <= res.slot;
      out_evict_r      <= res.evict;
      out_evict_page_r <= res.evict_page;
      out_hit_total_r  <= hit_total;
    end
  end

  lrupr_search u_search (
    .page   (s1_page_r),
    .active (active),
    .valid  (valid),
    .pages  (pages),
    .ranks  (ranks),
    .res    (res)
  );

  lrupr_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (fire),
    .page      (s1_page_r),
    .eos       (s1_eos_r),
    .active    (active),
    .res       (res),
    .pages     (pages),
    .valid     (valid),
    .ranks     (ranks),
    .hit_total (hit_total)
  );

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_slot_r;
  assign out_evicted_valid = out_evict_r;
  assign out_evicted_page  = out_evict_page_r;
  assign out_hit_total     = out_hit_total_r;

  `LRUPR_ASSERT_NEXT(a_result_follows, fire, out_valid_r, "no result after transfer")
  `LRUPR_ASSERT_NEXT(a_eos_clears, fire && s1_eos_r, (valid == '0) && (ranks == '0), "eos clear")
  `LRUPR_ASSERT_NEXT(a_fill_valid, fire && !s1_eos_r, valid[$past(res.slot)], "frame not valid")
  `LRUPR_ASSERT_NOW(a_hit_no_evict, fire && res.hit, !res.evict, "hit reported an eviction")

endmodule

`default_nettype wire
